// ===== design/lsvm_pkg.sv =====
// ----------------------------------------------------------------------------
// lsvm_pkg
// Shared constants, types and helpers of the latent SVM block argmax scorer.
// ----------------------------------------------------------------------------
package lsvm_pkg;

    localparam int MAX_FEATURES = 4096;
    localparam int MAX_BLOCKS   = 1024;
    localparam int VALUE_BITS   = 16;

    localparam int ADDR_W   = $clog2(MAX_FEATURES);
    localparam int BLOCK_W  = $clog2(MAX_BLOCKS);
    localparam int COUNT_W  = ADDR_W + 1;
    localparam int PROD_W   = 2 * VALUE_BITS;
    localparam int SCORE_W  = 48;
    localparam int WIDE_W   = SCORE_W + 2;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 64;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam int OUT_DEPTH = 8;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = OUT_PTR_W + 1;

    localparam logic [1:0] MODE_INFER    = 2'd0;
    localparam logic [1:0] MODE_CLASSIFY = 2'd1;
    localparam logic [1:0] MODE_VIOLATED = 2'd2;

    localparam logic REG_MODE          = 1'b0;
    localparam logic REG_FEATURE_COUNT = 1'b1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_FEED = 1'b1;

    localparam logic [COUNT_W-1:0] FEATURE_COUNT_RESET = COUNT_W'(MAX_FEATURES);

    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
    localparam logic signed [WIDE_W-1:0]  LOSS_ONE  = WIDE_W'(65536);

    typedef struct packed {
        logic signed [SCORE_W-1:0] best_score;
        logic                      best_label;
        logic [BLOCK_W-1:0]        best_index;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

    function automatic logic signed [SCORE_W-1:0] sat_score(input logic signed [WIDE_W-1:0] x);
        logic signed [SCORE_W-1:0] r;
        if (x[WIDE_W-1:SCORE_W-1] == '0 || x[WIDE_W-1:SCORE_W-1] == '1) begin
            r = x[SCORE_W-1:0];
        end else if (x[WIDE_W-1]) begin
            r = SCORE_MIN;
        end else begin
            r = SCORE_MAX;
        end
        return r;
    endfunction

endpackage

// ===== design/latent_svm_block_argmax_scorer_top.sv =====
// ----------------------------------------------------------------------------
// latent_svm_block_argmax_scorer_top
// Latent linear SVM scorer: block dot products against a weight memory and
// an argmax over the latent blocks of one example.
// ----------------------------------------------------------------------------
// Input stream: one transaction per weight load (tuser = 0) or feature element
//   (tuser = 1). tlast marks the final feature element of an example.
// Output stream: one transaction per example with best index, label and score.
// APB port: mode at 0x0, feature_count at 0x4; write only while idle.
// Throughput: one transaction per cycle while s_axis_tready is high, set by the
//   single-port weight memory read plus one multiply-accumulate per element.
// Result path: after the last element is accepted, m_axis_tvalid rises once it
//   has passed the weight read (at the accepting edge), multiply, accumulate,
//   candidate and select registers and the argmax result enters the buffer.
// Stall: results queue in an 8-entry output buffer; s_axis_tready drops only
//   once 8 results are buffered or in flight.
// Reset: registers return to mode 1 and feature_count 4096, per-example state
//   and the buffer clear. The weight memory is not cleared; load every weight
//   in use before streaming features.
// ----------------------------------------------------------------------------
module latent_svm_block_argmax_scorer_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [11:0] weight_address, [27:12] value, [28] true_label, [31:29] zero
    input  logic [lsvm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // [0] operation
    input  logic [0:0]                           s_axis_tuser,
    input  logic                                 s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [9:0] best_index, [10] best_label, [58:11] best_score, [63:59] zero
    output logic [lsvm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lsvm_pkg::PADDR_W-1:0]         paddr,
    input  logic [lsvm_pkg::PDATA_W-1:0]         pwdata,
    output logic [lsvm_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready
);
    import lsvm_pkg::*;

    // configuration
    logic [1:0]         r_mode;
    logic [COUNT_W-1:0] r_feature_count;
    logic [COUNT_W-1:0] active_count;
    logic               cfg_wr;
    logic               cfg_idx;

    // input decode
    logic                         in_acc;
    logic                         in_op;
    logic [ADDR_W-1:0]            in_addr;
    logic signed [VALUE_BITS-1:0] in_value;
    logic                         in_label;
    logic                         in_last;
    logic                         feed_acc;

    // front end
    logic signed [VALUE_BITS-1:0] weight_mem [MAX_FEATURES];
    logic [ADDR_W-1:0]            r_pos;
    logic [BLOCK_W-1:0]           r_blk;
    logic [COUNT_W-1:0]           pos_inc;
    logic                         s0_close;

    // stage 1: weight read
    logic                         r1_valid;
    logic signed [VALUE_BITS-1:0] r1_weight;
    logic signed [VALUE_BITS-1:0] r1_value;
    logic                         r1_label;
    logic                         r1_last;
    logic                         r1_close;
    logic [BLOCK_W-1:0]           r1_blk;

    // stage 2: product
    logic                     r2_valid;
    logic signed [PROD_W-1:0] r2_prod;
    logic                     r2_label;
    logic                     r2_last;
    logic                     r2_close;
    logic [BLOCK_W-1:0]       r2_blk;

    // stage 2 accumulator and stage 3: block score
    logic signed [SCORE_W-1:0] r_acc;
    logic signed [SCORE_W-1:0] acc_sum;
    logic                      r3_valid;
    logic signed [SCORE_W-1:0] r3_score;
    logic                      r3_label;
    logic                      r3_last;
    logic [BLOCK_W-1:0]        r3_blk;

    // stage 4: positive and negative candidates
    logic signed [WIDE_W-1:0]  s3_wide;
    logic signed [WIDE_W-1:0]  s3_loss_p;
    logic signed [WIDE_W-1:0]  s3_loss_n;
    logic                      r4_valid;
    logic signed [SCORE_W-1:0] r4_p;
    logic signed [SCORE_W-1:0] r4_n;
    logic                      r4_label;
    logic                      r4_last;
    logic [BLOCK_W-1:0]        r4_blk;

    // stage 5: chosen candidate
    logic                      r5_valid;
    logic signed [SCORE_W-1:0] r5_cand;
    logic                      r5_cls;
    logic                      r5_last;
    logic [BLOCK_W-1:0]        r5_blk;
    logic signed [SCORE_W-1:0] n5_cand;
    logic                      n5_cls;

    // argmax
    logic                      r_have;
    logic signed [SCORE_W-1:0] r_best_value;
    logic                      r_best_class;
    logic [BLOCK_W-1:0]        r_best_block;
    logic                      take;
    t_result                   n_result;

    // output buffer
    t_result              r_fifo [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_wr_ptr;
    logic [OUT_PTR_W-1:0] r_rd_ptr;
    logic [OUT_CNT_W-1:0] r_fcount;
    logic [OUT_CNT_W-1:0] r_pending;
    logic                 push;
    logic                 pop;

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= MODE_CLASSIFY;
            r_feature_count <= FEATURE_COUNT_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_MODE:          r_mode          <= pwdata[1:0];
                REG_FEATURE_COUNT: r_feature_count <= pwdata[COUNT_W-1:0];
                default:           r_mode          <= r_mode;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_MODE:          prdata = PDATA_W'(r_mode);
            REG_FEATURE_COUNT: prdata = PDATA_W'(r_feature_count);
            default:           prdata = '0;
        endcase
    end

    always_comb begin
        if (r_feature_count == '0) begin
            active_count = COUNT_W'(1);
        end else if (r_feature_count > FEATURE_COUNT_RESET) begin
            active_count = FEATURE_COUNT_RESET;
        end else begin
            active_count = r_feature_count;
        end
    end

    // ------------------------------------------------------------------------
    // input decode and block position
    // ------------------------------------------------------------------------
    assign s_axis_tready = (r_pending < OUT_CNT_W'(OUT_DEPTH));
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign in_op    = s_axis_tuser[0];
    assign in_addr  = s_axis_tdata[ADDR_W-1:0];
    assign in_value = s_axis_tdata[ADDR_W+VALUE_BITS-1:ADDR_W];
    assign in_label = s_axis_tdata[ADDR_W+VALUE_BITS];
    assign in_last  = s_axis_tlast;
    assign feed_acc = in_acc && (in_op == OP_FEED);

    assign pos_inc  = {1'b0, r_pos} + COUNT_W'(1);
    assign s0_close = in_last || (pos_inc >= active_count);

    always_ff @(posedge i_clk) begin
        if (in_acc && (in_op == OP_LOAD)) begin
            weight_mem[in_addr] <= in_value;
        end
        if (feed_acc) begin
            r1_weight <= weight_mem[r_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_blk <= '0;
        end else if (feed_acc) begin
            if (in_last) begin
                r_pos <= '0;
                r_blk <= '0;
            end else if (s0_close) begin
                r_pos <= '0;
                r_blk <= r_blk + BLOCK_W'(1);
            end else begin
                r_pos <= pos_inc[ADDR_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------------
    // pipeline control
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else begin
            r1_valid <= feed_acc;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid && r2_close;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        r1_value <= in_value;
        r1_label <= in_label;
        r1_last  <= in_last;
        r1_close <= s0_close;
        r1_blk   <= r_blk;
    end

    // stage 2: multiply
    always_ff @(posedge i_clk) begin
        r2_prod  <= r1_value * r1_weight;
        r2_label <= r1_label;
        r2_last  <= r1_last;
        r2_close <= r1_close;
        r2_blk   <= r1_blk;
    end

    // stage 3: accumulate, close block
    assign acc_sum = r_acc + {{(SCORE_W-PROD_W){r2_prod[PROD_W-1]}}, r2_prod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (r2_valid) begin
            r_acc <= r2_close ? '0 : acc_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_score <= acc_sum;
        r3_label <= r2_label;
        r3_last  <= r2_last;
        r3_blk   <= r2_blk;
    end

    // stage 4: candidates with loss
    assign s3_wide   = {{(WIDE_W-SCORE_W){r3_score[SCORE_W-1]}}, r3_score};
    assign s3_loss_p = (r_mode == MODE_VIOLATED && !r3_label) ? LOSS_ONE : '0;
    assign s3_loss_n = (r_mode == MODE_VIOLATED && r3_label) ? LOSS_ONE : '0;

    always_ff @(posedge i_clk) begin
        r4_p     <= sat_score(s3_wide + s3_loss_p);
        r4_n     <= sat_score(s3_loss_n - s3_wide);
        r4_label <= r3_label;
        r4_last  <= r3_last;
        r4_blk   <= r3_blk;
    end

    // stage 5: select candidate
    always_comb begin
        if (r_mode == MODE_INFER) begin
            n5_cand = r4_label ? r4_p : r4_n;
            n5_cls  = r4_label;
        end else if (r4_p >= r4_n) begin
            n5_cand = r4_p;
            n5_cls  = 1'b1;
        end else begin
            n5_cand = r4_n;
            n5_cls  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_cand <= n5_cand;
        r5_cls  <= n5_cls;
        r5_last <= r4_last;
        r5_blk  <= r4_blk;
    end

    // ------------------------------------------------------------------------
    // argmax over blocks
    // ------------------------------------------------------------------------
    always_comb begin
        if (!r_have) begin
            take = 1'b1;
        end else if (r_mode == MODE_INFER) begin
            take = r5_cand > r_best_value;
        end else begin
            take = r5_cand >= r_best_value;
        end
        n_result.best_score = take ? r5_cand : r_best_value;
        n_result.best_label = take ? r5_cls  : r_best_class;
        n_result.best_index = take ? r5_blk  : r_best_block;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have       <= 1'b0;
            r_best_value <= '0;
            r_best_class <= 1'b0;
            r_best_block <= '0;
        end else if (r5_valid) begin
            if (r5_last) begin
                r_have       <= 1'b0;
                r_best_value <= '0;
                r_best_class <= 1'b0;
                r_best_block <= '0;
            end else begin
                r_have       <= 1'b1;
                r_best_value <= n_result.best_score;
                r_best_class <= n_result.best_label;
                r_best_block <= n_result.best_index;
            end
        end
    end

    // ------------------------------------------------------------------------
    // output buffer
    // ------------------------------------------------------------------------
    assign push = r5_valid && r5_last;
    assign pop  = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_fcount  <= '0;
            r_pending <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + OUT_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + OUT_PTR_W'(1);
            end
            r_fcount  <= r_fcount + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
            r_pending <= r_pending + OUT_CNT_W'(feed_acc && in_last) - OUT_CNT_W'(pop);
        end
    end

    assign m_axis_tvalid = (r_fcount != '0);
    assign m_axis_tdata  = OUT_TDATA_W'(r_fifo[r_rd_ptr]);

endmodule

// ===== design/lsvm_checker.sv =====
// ----------------------------------------------------------------------------
// lsvm_checker
// Port-level checks of the latent SVM block argmax scorer.
// ----------------------------------------------------------------------------
module lsvm_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [lsvm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic [0:0]                       s_axis_tuser,
    input logic                             s_axis_tlast,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [lsvm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             psel,
    input logic                             penable,
    input logic                             pwrite,
    input logic [lsvm_pkg::PADDR_W-1:0]     paddr,
    input logic [lsvm_pkg::PDATA_W-1:0]     pwdata,
    input logic [lsvm_pkg::PDATA_W-1:0]     prdata,
    input logic                             pready
);
    import lsvm_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result shown right after reset");

    a_backpressure_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result waiting");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:RESULT_W] == '0)
        else $error("result padding not zero");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("configuration port not ready");

endmodule

bind latent_svm_block_argmax_scorer_top lsvm_checker u_lsvm_checker (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the latent SVM block argmax scorer end to end. A scripted opening
// covers reset defaults, Q8.8 extremes, every mode including the reserved one,
// clamped feature counts, early example ends and last marks on weight loads.
// After a short preload of the weights that random examples read, random
// examples follow. Each phase picks a new mode and block size, and weight
// loads are mixed in between feature elements. A scoreboard model predicts every
// decision that the script does not fix, and both stream sides idle at random.
// ----------------------------------------------------------------------------
module testbench;

    import lsvm_pkg::*;

    localparam logic [1:0] MODE_RESERVED = 2'd3;
    localparam int SETTLE_CYCLES = 12;
    localparam int SCRIPT_LEN = 31;
    localparam int PRELOAD_WORDS = 16;
    localparam int RANDOM_ITEMS = 460;

    typedef struct {
        logic               op;
        logic [ADDR_W-1:0]  addr;
        logic signed [15:0] val;
        logic               label;
        logic               last;
    } t_elem;

    typedef enum logic [1:0] {ROW_LOAD, ROW_FEED, ROW_MODE, ROW_COUNT} t_row_kind;

    typedef struct {
        t_row_kind                 kind;
        logic [ADDR_W-1:0]         addr;
        logic [31:0]               data;
        logic                      label;
        logic                      last;
        bit                        typed;
        logic [BLOCK_W-1:0]        idx;
        logic                      lbl;
        logic signed [SCORE_W-1:0] score;
    } t_row;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    // [11:0] weight_address, [27:12] value, [28] true_label, [31:29] zero
    logic [IN_TDATA_W-1:0]   s_axis_tdata;
    // [0] operation
    logic [0:0]              s_axis_tuser;
    logic                    s_axis_tlast;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    // [9:0] best_index, [10] best_label, [58:11] best_score, [63:59] zero
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [PADDR_W-1:0]      paddr;
    logic [PDATA_W-1:0]      pwdata;
    logic [PDATA_W-1:0]      prdata;
    logic                    pready;

    latent_svm_block_argmax_scorer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // scoreboard model state
    logic [1:0]                cfg_mode;
    logic [COUNT_W-1:0]        cfg_count;
    logic signed [15:0]        weights [MAX_FEATURES];
    int unsigned               pos;
    logic [BLOCK_W-1:0]        blk;
    logic signed [SCORE_W-1:0] acc;
    longint                    best_val;
    logic [BLOCK_W-1:0]        best_blk;
    logic                      best_cls;
    bit                        have_best;

    t_result pending_decisions [$];
    int      elements_driven;
    bit      sender_steady;
    bit      receiver_steady;
    bit      failed;
    t_row    script [SCRIPT_LEN];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic longint clamp48(input longint x);
        if (x > longint'(SCORE_MAX)) return longint'(SCORE_MAX);
        if (x < longint'(SCORE_MIN)) return longint'(SCORE_MIN);
        return x;
    endfunction

    function automatic logic signed [15:0] rand_q88();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic score_element(input t_elem e, output bit emits, output t_result r);
        int unsigned span;
        longint      s;
        longint      p;
        longint      n;
        longint      cand;
        logic        cls;
        bit          take;
        emits = 1'b0;
        r = '0;
        span = (cfg_count == 0) ? 1 : (cfg_count > MAX_FEATURES) ? MAX_FEATURES : cfg_count;
        if (e.op == OP_LOAD) begin
            weights[e.addr] = e.val;
        end else begin
            acc = acc + SCORE_W'(longint'(e.val) * longint'(weights[pos]));
            pos++;
            if (pos >= span || e.last) begin
                s = longint'(acc);
                if (cfg_mode == MODE_INFER) begin
                    cand = e.label ? s : clamp48(-s);
                    cls = e.label;
                    take = !have_best || cand > best_val;
                end else begin
                    p = s;
                    n = clamp48(-s);
                    if (cfg_mode == MODE_VIOLATED) begin
                        if (e.label) n = clamp48(n + longint'(LOSS_ONE));
                        else p = clamp48(p + longint'(LOSS_ONE));
                    end
                    if (p >= n) begin
                        cand = p;
                        cls = 1'b1;
                    end else begin
                        cand = n;
                        cls = 1'b0;
                    end
                    take = !have_best || cand >= best_val;
                end
                if (take) begin
                    best_val = cand;
                    best_cls = cls;
                    best_blk = blk;
                    have_best = 1'b1;
                end
                blk = blk + 1'b1;
                pos = 0;
                acc = '0;
            end
            if (e.last) begin
                emits = 1'b1;
                r.best_index = best_blk;
                r.best_label = best_cls;
                r.best_score = best_val[SCORE_W-1:0];
                pos = 0;
                blk = '0;
                acc = '0;
                best_val = 0;
                best_blk = '0;
                best_cls = 1'b0;
                have_best = 1'b0;
            end
        end
    endtask

    task automatic send_element(input t_elem e, input bit typed, input t_result typed_res);
        int      gap;
        bit      emits;
        t_result r;
        gap = sender_steady ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, e.label, e.val, e.addr};
        s_axis_tuser  <= e.op;
        s_axis_tlast  <= e.last;
        do @(posedge i_clk); while (!s_axis_tready);
        score_element(e, emits, r);
        if (emits) pending_decisions.push_back(typed ? typed_res : r);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_decisions.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic reg_idx, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        if (reg_idx == REG_MODE) cfg_mode = v[1:0];
        else cfg_count = v[COUNT_W-1:0];
    endtask

    task automatic program_block(input logic [1:0] m, input logic [COUNT_W-1:0] cnt);
        settle();
        write_reg(REG_MODE, 32'(m));
        write_reg(REG_FEATURE_COUNT, 32'(cnt));
    endtask

    task automatic send_example(input int blocks, input int block_len, input int tail_len,
                                input bit noisy);
        t_elem e;
        logic  label;
        int    len;
        label = 1'($urandom());
        for (int b = 0; b < blocks; b++) begin
            len = (b == blocks - 1) ? tail_len : block_len;
            for (int k = 0; k < len; k++) begin
                if (noisy && $urandom_range(0, 9) == 0) begin
                    e = '{OP_LOAD, 12'($urandom()), rand_q88(), 1'($urandom()), 1'($urandom())};
                    send_element(e, 1'b0, '0);
                    elements_driven++;
                end
                e.op    = OP_FEED;
                e.addr  = 12'($urandom());
                e.val   = rand_q88();
                e.label = label ^ (noisy && $urandom_range(0, 15) == 0);
                e.last  = (b == blocks - 1) && (k == len - 1);
                send_element(e, 1'b0, '0);
                elements_driven++;
            end
        end
    endtask

    initial begin
        int unsigned span;
        logic [1:0]  mode_list [4];
        logic [1:0]  m;
        logic [COUNT_W-1:0] cnt;
        t_elem   e;
        t_result want;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        failed        = 1'b0;
        sender_steady = 1'b0;
        receiver_steady = 1'b0;
        cfg_mode      = MODE_CLASSIFY;
        cfg_count     = FEATURE_COUNT_RESET;
        pos = 0;
        blk = '0;
        acc = '0;
        best_val = 0;
        best_blk = '0;
        best_cls = 1'b0;
        have_best = 1'b0;
        mode_list = '{MODE_INFER, MODE_CLASSIFY, MODE_VIOLATED, MODE_RESERVED};

        script = '{
            '{ROW_LOAD,  12'd0,   32'h0100, 1'b0, 1'b0, 1'b0, 10'd0, 1'b0, 48'sd0},
            '{ROW_FEED,  12'd0,   32'h0100, 1'b0, 1'b1, 1'b1, 10'd0, 1'b1, 48'sd65536},
            '{ROW_LOAD,  12'd0,   32'h8000, 1'b0, 1'b0, 1'b0, 10'd0, 1'b0, 48'sd0},
            '{ROW_LOAD,  12'd1,   32'h7FFF, 1'b0, 1'b0, 1'b0, 10'd0, 1'b0, 48'sd0},
            '{ROW_LOAD,  12'hFFF, 32'h7FFF, 1'b1, 1'b1, 1'b0, 10'd0, 1'b0, 48'sd0},
            '{ROW_FEED,  12'd0,   32'h8000, 1'b1, 1'b1, 1'b1, 10'd0, 1'b1, 48'sd1073741824},
            '{ROW_FEED,  12'd0,   32'h7FFF, 1'b0, 1'b0, 1'b0, 10'd0, 1'b0, 48'sd0},
            '{ROW_FEED,  12'd0,   32'h7FFF, 1'b0, 1'b1, 1'b0, 10'd0, 1'b0, 48'sd0},
            '{ROW_MODE,  12'd0,   32'(MODE_INFER), 1'b0, 1'b0, 1'b0, 10'd0, 1'b0, 48'sd0},
            '{ROW_COUNT, 12'd0,   32'd1,    1'b0, 1'b0, 1'b0, 10'd0, 1'b0, 48'sd0},
            '{ROW_FEED,  12'd0,   32'h0100, 1'b1, 1'b0, 1'b0, 10'd0, 1'b0, 48'sd0},
            '{ROW_FEED,  12'd0,   32'h0000, 1'b1, 1'b1, 1'b0, 10'd0, 1'b0, 48'sd0},
            '{ROW_FEED,  12'd0,   32'h0000, 1'b0, 1'b0, 1'b0, 10'd0, 1'b0, 48'sd0},
            '{ROW_FEED,  12'd0,   32'h0000, 1'b0, 1'b1, 1'b1, 10'd0, 1'b0, 48'sd0},
            '{ROW_MODE,  12'd0,   32'(MODE_VIOLATED), 1'b0, 1'b0, 1'b0, 10'd0, 1'b0, 48'sd0},
            '{ROW_FEED,  12'd0,   32'h0000, 1'b0, 1'b1, 1'b1, 10'd0, 1'b1, 48'sd65536},
            '{ROW_FEED,  12'd0,   32'h0000, 1'b1, 1'b1, 1'b1, 10'd0, 1'b0, 48'sd65536},
            '{ROW_MODE,  12'd0,   32'(MODE_RESERVED), 1'b0, 1'b0, 1'b0, 10'd0, 1'b0, 48'sd0},
            '{ROW_FEED,  12'd0,   32'h0000, 1'b0, 1'b0, 1'b0, 10'd0, 1'b0, 48'sd0},
            '{ROW_FEED,  12'd0,   32'h0000, 1'b0, 1'b1, 1'b1, 10'd1, 1'b1, 48'sd0},
            '{ROW_COUNT, 12'd0,   32'd0,    1'b0, 1'b0, 1'b0, 10'd0, 1'b0, 48'sd0},
            '{ROW_FEED,  12'd0,   32'h0100, 1'b0, 1'b0, 1'b0, 10'd0, 1'b0, 48'sd0},
            '{ROW_FEED,  12'd0,   32'h8000, 1'b0, 1'b1, 1'b0, 10'd0, 1'b0, 48'sd0},
            '{ROW_COUNT, 12'd0,   32'h1FFF, 1'b0, 1'b0, 1'b0, 10'd0, 1'b0, 48'sd0},
            '{ROW_FEED,  12'd0,   32'h7FFF, 1'b1, 1'b0, 1'b0, 10'd0, 1'b0, 48'sd0},
            '{ROW_FEED,  12'd0,   32'h8000, 1'b1, 1'b1, 1'b0, 10'd0, 1'b0, 48'sd0},
            '{ROW_MODE,  12'd0,   32'(MODE_CLASSIFY), 1'b0, 1'b0, 1'b0, 10'd0, 1'b0, 48'sd0},
            '{ROW_COUNT, 12'd0,   32'd2,    1'b0, 1'b0, 1'b0, 10'd0, 1'b0, 48'sd0},
            '{ROW_FEED,  12'd0,   32'h0001, 1'b0, 1'b0, 1'b0, 10'd0, 1'b0, 48'sd0},
            '{ROW_FEED,  12'd0,   32'hFFFF, 1'b0, 1'b0, 1'b0, 10'd0, 1'b0, 48'sd0},
            '{ROW_FEED,  12'd0,   32'h4000, 1'b0, 1'b1, 1'b0, 10'd0, 1'b0, 48'sd0}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) begin
            case (script[i].kind)
                ROW_MODE: begin
                    settle();
                    write_reg(REG_MODE, script[i].data);
                end
                ROW_COUNT: begin
                    settle();
                    write_reg(REG_FEATURE_COUNT, script[i].data);
                end
                default: begin
                    e.op    = (script[i].kind == ROW_LOAD) ? OP_LOAD : OP_FEED;
                    e.addr  = script[i].addr;
                    e.val   = script[i].data[15:0];
                    e.label = script[i].label;
                    e.last  = script[i].last;
                    want.best_index = script[i].idx;
                    want.best_label = script[i].lbl;
                    want.best_score = script[i].score;
                    send_element(e, script[i].typed, want);
                end
            endcase
        end

        // preload the weights that random examples read
        for (int a = 0; a < PRELOAD_WORDS; a++) begin
            e = '{OP_LOAD, 12'(a), rand_q88(), 1'($urandom()), 1'($urandom())};
            send_element(e, 1'b0, '0);
        end

        elements_driven = 0;
        while (elements_driven < RANDOM_ITEMS) begin
            m = mode_list[$urandom_range(0, 3)];
            case ($urandom_range(0, 9))
                0: cnt = '0;
                1: cnt = '1;
                2: cnt = COUNT_W'($urandom_range(MAX_FEATURES + 1, 8190));
                3: cnt = FEATURE_COUNT_RESET;
                default: cnt = COUNT_W'($urandom_range(1, 8));
            endcase
            program_block(m, cnt);
            span = (cnt == 0) ? 1 : (cnt > MAX_FEATURES) ? MAX_FEATURES : cnt;
            sender_steady = ($urandom_range(0, 3) == 0);
            receiver_steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 4)) begin
                if (span > 16) send_example(1, span, $urandom_range(1, 16), 1'b1);
                else send_example($urandom_range(1, 5), span,
                                  ($urandom_range(0, 2) == 0) ? $urandom_range(1, span) : span,
                                  1'b1);
            end
        end

        settle();
        if (!failed) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        int hold;
        m_axis_tready = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            hold = receiver_steady ? 0 : $urandom_range(0, 17);
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[RESULT_W-1:0]);
            if (pending_decisions.size() == 0) begin
                $display("%0t ns: expected no decision, actual index %0d label %0d score %0d",
                         $time, got.best_index, got.best_label, got.best_score);
                failed = 1'b1;
            end else begin
                want = pending_decisions.pop_front();
                if (got.best_index !== want.best_index) begin
                    $display("%0t ns: best_index expected %0d actual %0d",
                             $time, want.best_index, got.best_index);
                    failed = 1'b1;
                end
                if (got.best_label !== want.best_label) begin
                    $display("%0t ns: best_label expected %0d actual %0d",
                             $time, want.best_label, got.best_label);
                    failed = 1'b1;
                end
                if (got.best_score !== want.best_score) begin
                    $display("%0t ns: best_score expected %0d actual %0d",
                             $time, want.best_score, got.best_score);
                    failed = 1'b1;
                end
            end
        end
    end

endmodule
